@@ hdl/uer_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger: shared types and constants
// Payload structures for the tick and result channels, register indexes,
// reset values and the reciprocal constants for the unit conversions.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int WIDTH_W = 16;
	localparam int CM_W    = 11;
	localparam int INCH_W  = 9;
	localparam int TMO_W   = 16;
	localparam int THR_W   = 11;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TIMEOUT = 1'd0;
	localparam logic [IDX_W-1:0] REG_NEAR    = 1'd1;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd26100;
	localparam logic [THR_W-1:0] NEAR_RESET    = 11'd20;

	localparam int TRIG_LOW_TICKS = 2;

	// width / 58 = (width * 72316) >> 22, exact for all 16-bit widths
	// width / 148 = (width * 113360) >> 24, exact for all 16-bit widths
	localparam int MUL_W    = 17;
	localparam int PROD_W   = WIDTH_W + MUL_W;
	localparam logic [MUL_W-1:0] CM_MUL   = 17'd72316;
	localparam int               CM_SHIFT = 22;
	localparam logic [MUL_W-1:0] IN_MUL   = 17'd113360;
	localparam int               IN_SHIFT = 24;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} uer_in_t;

	typedef struct packed {
		logic               trigger_level;
		logic               busy_res;
		logic               done_res;
		logic               reading_valid;
		logic [WIDTH_W-1:0] pulse_width_us;
		logic [CM_W-1:0]    distance_cm;
		logic [INCH_W-1:0]  distance_inch;
		logic               too_close;
	} uer_res_t;

endpackage
`default_nettype wire

@@ hdl/uer_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger: channel interfaces
// Valid/ready channels for the tick items and for the result items.
// ----------------------------------------------------------------------------
interface uer_in_if;
	logic            valid;
	logic            ready;
	uer_pkg::uer_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface uer_res_if;
	logic             valid;
	logic             ready;
	uer_pkg::uer_res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ultrasonic_echo_ranger.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger/echo range measurement sequencer with cm and inch conversion.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transaction per microsecond tick, carrying a start request and
//            the sampled echo level. The trigger sequencer advances once per
//            accepted transaction, so pace the channel at the pin sample rate.
//   result : exactly one transaction per tick transaction, in order, giving the
//            trigger level to drive, busy/done status and, on the finishing
//            tick, the pulse width, centimetres, inches and the too-close flag.
//   cfg    : cfg_we/cfg_index/cfg_wdata write timeout_us (index 0) and
//            near_threshold_cm (index 1); write only while no result is pending.
// Timing: three register stages (sequencer, reciprocal multiply, scale and
//   compare); one tick is taken every cycle while the result channel is not
//   stalled. The reciprocal multipliers set the stage split.
// Reset: sequencer idle, counter zero, registers at 26100 us and 20 cm, no
//   result pending. A stalled receiver holds the result; ticks keep flowing
//   until all three stages are full, then tick.ready drops.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
	parameter int TRIG_HIGH_TICKS = 10,
	parameter int COUNT_WIDTH     = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	uer_in_if.sink                      tick,
	uer_res_if.source                   result,
	input  wire                         cfg_we,
	input  wire [uer_pkg::IDX_W-1:0]    cfg_index,
	input  wire [uer_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
	localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
	localparam logic [2:0] PH_WAIT_RISE = 3'd3;
	localparam logic [2:0] PH_MEASURE   = 3'd4;

	// common width for counter/timeout compares and the width field
	localparam int EW = (COUNT_WIDTH > uer_pkg::WIDTH_W) ? COUNT_WIDTH : uer_pkg::WIDTH_W;

	// ---------------- configuration registers ----------------
	logic [uer_pkg::TMO_W-1:0] timeout_q;
	logic [uer_pkg::THR_W-1:0] near_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= uer_pkg::TIMEOUT_RESET;
			near_thr_q <= uer_pkg::NEAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uer_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata[uer_pkg::TMO_W-1:0];
				uer_pkg::REG_NEAR:    near_thr_q <= cfg_wdata[uer_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic tick_acc;

	// each stage loads when it is empty or its content moves on this cycle
	assign rdy_s3     = !v_s3 || result.ready;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign tick.ready = rdy_s1;
	assign tick_acc   = tick.valid && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= tick.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// ---------------- sequencer ----------------
	logic [2:0]             phase_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic [2:0]             ph_cur, ph_nxt;
	logic [COUNT_WIDTH-1:0] cnt_cur, cnt_nxt, cnt_inc;
	logic [EW-1:0]          cnt_ext, tmo_ext;
	logic                   timed_out;
	logic                   trig_c, busy_c, done_c, valid_c;
	logic [uer_pkg::WIDTH_W-1:0] width_c;

	always_comb begin
		ph_cur  = (phase_q > PH_MEASURE) ? PH_IDLE : phase_q;
		cnt_cur = cnt_q;
		trig_c  = 1'b0;
		busy_c  = 1'b1;
		done_c  = 1'b0;
		valid_c = 1'b0;

		// start while idle enters the trigger-low phase on this same tick
		if (ph_cur == PH_IDLE) begin
			if (tick.data.start_req) begin
				ph_cur  = PH_TRIG_LOW;
				cnt_cur = '0;
			end else begin
				busy_c = 1'b0;
			end
		end

		ph_nxt    = ph_cur;
		cnt_inc   = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
		cnt_nxt   = cnt_cur;
		cnt_ext   = EW'(cnt_cur);
		tmo_ext   = EW'(timeout_q);
		timed_out = (cnt_ext >= tmo_ext) || (cnt_cur == '1);
		width_c   = cnt_ext[uer_pkg::WIDTH_W-1:0];

		unique case (ph_cur)
			PH_TRIG_LOW: begin
				cnt_nxt = cnt_inc;
				if (cnt_inc >= COUNT_WIDTH'(uer_pkg::TRIG_LOW_TICKS)) begin
					ph_nxt  = PH_TRIG_HIGH;
					cnt_nxt = '0;
				end
			end
			PH_TRIG_HIGH: begin
				trig_c  = 1'b1;
				cnt_nxt = cnt_inc;
				if (cnt_inc >= COUNT_WIDTH'(TRIG_HIGH_TICKS)) begin
					ph_nxt  = PH_WAIT_RISE;
					cnt_nxt = '0;
				end
			end
			PH_WAIT_RISE: begin
				if (tick.data.echo_level) begin
					ph_nxt  = PH_MEASURE;
					cnt_nxt = COUNT_WIDTH'(1);
				end else if (timed_out) begin
					done_c = 1'b1;
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
			PH_MEASURE: begin
				if (!tick.data.echo_level) begin
					done_c  = 1'b1;
					valid_c = (width_c != '0);
				end else if (timed_out) begin
					done_c = 1'b1;
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
			default: ;
		endcase

		if (done_c) begin
			busy_c  = 1'b0;
			ph_nxt  = PH_IDLE;
			cnt_nxt = '0;
		end
		if (!valid_c) begin
			width_c = '0;
		end
	end

	// advance the sequencer only on an accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else if (tick_acc) begin
			phase_q <= ph_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// ---------------- stage 1: sequencer outputs ----------------
	logic                        trig_s1, busy_s1, done_s1, valid_s1;
	logic [uer_pkg::WIDTH_W-1:0] width_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			trig_s1  <= trig_c;
			busy_s1  <= busy_c;
			done_s1  <= done_c;
			valid_s1 <= valid_c;
			width_s1 <= width_c;
		end
	end

	// ---------------- stage 2: reciprocal multiply ----------------
	logic                        trig_s2, busy_s2, done_s2, valid_s2;
	logic [uer_pkg::WIDTH_W-1:0] width_s2;
	logic [uer_pkg::PROD_W-1:0]  cm_prod_s2, in_prod_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			trig_s2    <= trig_s1;
			busy_s2    <= busy_s1;
			done_s2    <= done_s1;
			valid_s2   <= valid_s1;
			width_s2   <= width_s1;
			cm_prod_s2 <= uer_pkg::PROD_W'(width_s1) * uer_pkg::PROD_W'(uer_pkg::CM_MUL);
			in_prod_s2 <= uer_pkg::PROD_W'(width_s1) * uer_pkg::PROD_W'(uer_pkg::IN_MUL);
		end
	end

	// ---------------- stage 3: scale, compare, result register ----------------
	logic [uer_pkg::CM_W-1:0]   cm_c;
	logic [uer_pkg::INCH_W-1:0] inch_c;
	uer_pkg::uer_res_t          res_s3;

	assign cm_c   = cm_prod_s2[uer_pkg::CM_SHIFT +: uer_pkg::CM_W];
	assign inch_c = in_prod_s2[uer_pkg::IN_SHIFT +: uer_pkg::INCH_W];

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			res_s3.trigger_level  <= trig_s2;
			res_s3.busy_res       <= busy_s2;
			res_s3.done_res       <= done_s2;
			res_s3.reading_valid  <= valid_s2;
			res_s3.pulse_width_us <= width_s2;
			res_s3.distance_cm    <= cm_c;
			res_s3.distance_inch  <= inch_c;
			res_s3.too_close      <= valid_s2 && (cm_c != '0) && (cm_c <= near_thr_q);
		end
	end

	assign result.valid = v_s3;
	assign result.data  = res_s3;

endmodule
`default_nettype wire

@@ hdl/uer_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger: port checker
// Watches the channels of the top level and checks the handshakes and results.
// ----------------------------------------------------------------------------
module uer_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    in_valid,
	input wire                    in_ready,
	input wire                    res_valid,
	input wire                    res_ready,
	input wire uer_pkg::uer_res_t res_data
);

	logic       in_acc, res_acc;
	logic [2:0] inflight_q;

	assign in_acc  = in_valid && in_ready;
	assign res_acc = res_valid && res_ready;

	// count transactions inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !res_acc) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (!in_acc && res_acc) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 3'd0)
		else $error("result without an accepted tick");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more ticks held than pipeline stages");

	a_cm: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.reading_valid |->
			(18'(res_data.distance_cm) * 18'd58 <= 18'(res_data.pulse_width_us)) &&
			(18'(res_data.pulse_width_us) < (18'(res_data.distance_cm) + 18'd1) * 18'd58) &&
			(18'(res_data.distance_inch) * 18'd148 <= 18'(res_data.pulse_width_us)) &&
			(18'(res_data.pulse_width_us) < (18'(res_data.distance_inch) + 18'd1) * 18'd148))
		else $error("distance does not match pulse width");

	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid)
		else $error("result pending straight after reset");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tick.valid),
	.in_ready  (tick.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Feeds microsecond ticks that carry start requests and echo levels, then
// compares every result transaction with a tick-level prediction of the
// trigger/echo sequencer and its unit conversion. The directed part covers
// the register extremes and the timeouts. The random part runs well-formed
// measurements with noise bursts under three idling regimes.
// ----------------------------------------------------------------------------
module tb;

	localparam int          HALF_PERIOD     = 5;
	localparam int          RESET_CYCLES    = 5;
	localparam int          TRIG_HIGH_TICKS = 10;
	localparam int          COUNT_WIDTH     = 16;
	localparam int unsigned COUNT_MAX       = (1 << COUNT_WIDTH) - 1;
	localparam int unsigned CM_DIV          = 58;
	localparam int unsigned INCH_DIV        = 148;
	// the block holds three register stages; allow a margin over that
	localparam int          DRAIN_CYCLES    = 8;
	localparam int          STALL_LIMIT     = 2000;
	localparam int          RANDOM_TICKS    = 420;
	localparam int          RANDOM_PHASES   = 6;
	localparam int          REPORT_LIMIT    = 10;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_TRIG_LOW,
		SEQ_TRIG_HIGH,
		SEQ_WAIT_RISE,
		SEQ_MEASURE
	} seq_phase_e;

	// Tracks the sequencer tick by tick and holds the readings still owed
	class echo_range_tracker;
		seq_phase_e         phase;
		int unsigned        elapsed;
		int unsigned        timeout_us;
		int unsigned        near_cm;
		uer_pkg::uer_res_t  pending_readings[$];
		int unsigned        mismatches;

		function new();
			phase      = SEQ_IDLE;
			elapsed    = 0;
			timeout_us = uer_pkg::TIMEOUT_RESET;
			near_cm    = uer_pkg::NEAR_RESET;
			mismatches = 0;
		endfunction

		function void write_register(logic [uer_pkg::IDX_W-1:0] index,
				logic [uer_pkg::CFG_W-1:0] value);
			if (index == uer_pkg::REG_TIMEOUT)
				timeout_us = value[uer_pkg::TMO_W-1:0];
			else if (index == uer_pkg::REG_NEAR)
				near_cm = value[uer_pkg::THR_W-1:0];
		endfunction

		function bit at_rest();
			return phase == SEQ_IDLE;
		endfunction

		function bit drained();
			return pending_readings.size() == 0;
		endfunction

		function int unsigned bump(int unsigned c);
			return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
		endfunction

		function bit expired(int unsigned c);
			return c >= timeout_us || c >= COUNT_MAX;
		endfunction

		function void note_tick(uer_pkg::uer_in_t t);
			uer_pkg::uer_res_t r;
			bit                finished;
			bit                good;
			int unsigned       width;
			int unsigned       cm;
			r          = '0;
			finished   = 1'b0;
			good       = 1'b0;
			width      = 0;
			r.busy_res = 1'b1;
			if (phase == SEQ_IDLE) begin
				if (t.start_req) begin
					phase   = SEQ_TRIG_LOW;
					elapsed = 0;
				end else begin
					r.busy_res = 1'b0;
				end
			end
			case (phase)
				SEQ_TRIG_LOW: begin
					elapsed = bump(elapsed);
					if (elapsed >= uer_pkg::TRIG_LOW_TICKS) begin
						phase   = SEQ_TRIG_HIGH;
						elapsed = 0;
					end
				end
				SEQ_TRIG_HIGH: begin
					r.trigger_level = 1'b1;
					elapsed = bump(elapsed);
					if (elapsed >= TRIG_HIGH_TICKS) begin
						phase   = SEQ_WAIT_RISE;
						elapsed = 0;
					end
				end
				SEQ_WAIT_RISE: begin
					if (t.echo_level) begin
						phase   = SEQ_MEASURE;
						elapsed = 1;
					end else if (expired(elapsed)) begin
						finished = 1'b1;
					end else begin
						elapsed = bump(elapsed);
					end
				end
				SEQ_MEASURE: begin
					if (!t.echo_level) begin
						finished = 1'b1;
						width    = elapsed & 32'hFFFF;
						good     = width != 0;
					end else if (expired(elapsed)) begin
						finished = 1'b1;
					end else begin
						elapsed = bump(elapsed);
					end
				end
				default: ;
			endcase
			if (finished) begin
				r.busy_res = 1'b0;
				r.done_res = 1'b1;
				phase      = SEQ_IDLE;
				elapsed    = 0;
				if (good) begin
					cm               = width / CM_DIV;
					r.reading_valid  = 1'b1;
					r.pulse_width_us = uer_pkg::WIDTH_W'(width);
					r.distance_cm    = uer_pkg::CM_W'(cm);
					r.distance_inch  = uer_pkg::INCH_W'(width / INCH_DIV);
					r.too_close      = (cm > 0) && (cm <= near_cm);
				end
			end
			pending_readings.push_back(r);
		endfunction

		function void flag(string what, int unsigned want, int unsigned got);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void compare(string what, int unsigned want, int unsigned got);
			if (want != got)
				flag(what, want, got);
		endfunction

		function void match_reading(uer_pkg::uer_res_t got);
			uer_pkg::uer_res_t want;
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("[%0t] result with none outstanding: %p", $time, got);
				return;
			end
			want = pending_readings.pop_front();
			compare("trigger_level", 32'(want.trigger_level), 32'(got.trigger_level));
			compare("busy_res", 32'(want.busy_res), 32'(got.busy_res));
			compare("done_res", 32'(want.done_res), 32'(got.done_res));
			compare("reading_valid", 32'(want.reading_valid), 32'(got.reading_valid));
			compare("pulse_width_us", 32'(want.pulse_width_us), 32'(got.pulse_width_us));
			compare("distance_cm", 32'(want.distance_cm), 32'(got.distance_cm));
			compare("distance_inch", 32'(want.distance_inch), 32'(got.distance_inch));
			compare("too_close", 32'(want.too_close), 32'(got.too_close));
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [uer_pkg::IDX_W-1:0]  cfg_index;
	logic [uer_pkg::CFG_W-1:0]  cfg_wdata;

	uer_in_if  tick_if ();
	uer_res_if res_if ();

	echo_range_tracker tracker;
	int unsigned       src_idle_pct;
	int unsigned       snk_idle_pct;
	int unsigned       ticks_sent;
	int unsigned       stall_cycles;

	ultrasonic_echo_ranger #(
		.TRIG_HIGH_TICKS(TRIG_HIGH_TICKS),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_if),
		.result   (res_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Receiver side: decide the stall for the next edge on the falling edge
	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Sample both channels on the rising edge. Note the tick before checking
	// so a transaction is always predicted before its result could appear.
	// Any edge with no transaction on either channel advances the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_if.valid && tick_if.ready)
				tracker.note_tick(tick_if.data);
			if (res_if.valid && res_if.ready)
				tracker.match_reading(res_if.data);
			if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("ultrasonic_echo_ranger verification failed");
				$finish;
			end
		end
	end

	// Offer one tick and hold it until taken; returns on the following falling
	// edge with valid still high, so the next call either keeps or drops it.
	task automatic send_tick(input bit start, input bit echo);
		uer_pkg::uer_in_t item;
		item.start_req  = start;
		item.echo_level = echo;
		while ($urandom_range(99) < src_idle_pct) begin
			tick_if.valid <= 1'b0;
			@(negedge clk);
		end
		tick_if.valid <= 1'b1;
		tick_if.data  <= item;
		do @(posedge clk); while (!tick_if.ready);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Drop the tick channel, let every result out and the pipeline empty,
	// then write one register.
	task automatic write_reg(input logic [uer_pkg::IDX_W-1:0] index,
			input int unsigned value);
		tick_if.valid <= 1'b0;
		while (!tracker.drained())
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= uer_pkg::CFG_W'(value);
		tracker.write_register(index, uer_pkg::CFG_W'(value));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Feed quiet ticks until the sequencer is back at idle; a pending rise
	// wait ends by timeout, a pulse ends on the first low echo.
	task automatic settle_idle();
		while (!tracker.at_rest())
			send_tick(1'b0, 1'b0);
	endtask

	// One measurement: start, eleven trigger ticks with stray starts and echo
	// glitches that must be ignored, the rise wait, the pulse and the falling
	// tick, which may carry a start that must be ignored too.
	task automatic run_echo(input int unsigned rise_wait, input int unsigned pulse,
			input bit start_on_finish);
		send_tick(1'b1, 1'($urandom_range(1)));
		repeat (uer_pkg::TRIG_LOW_TICKS + TRIG_HIGH_TICKS - 1)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (rise_wait) send_tick(1'b0, 1'b0);
		repeat (pulse) send_tick(1'b0, 1'b1);
		send_tick(start_on_finish, 1'b0);
	endtask

	// Broken sequences: random echo with the odd start
	task automatic send_noise();
		repeat ($urandom_range(5, 30))
			send_tick($urandom_range(7) == 0, 1'($urandom_range(1)));
	endtask

	// Land one below, on, or one past the given count
	function automatic int unsigned around(int unsigned t);
		return t + $urandom_range(2) - 1;
	endfunction

	// Mostly short budgets so timeouts come often; the top band reaches
	// pulses of at least one centimetre.
	function automatic int unsigned pick_timeout();
		case ($urandom_range(2))
			0:       return $urandom_range(1, 6);
			1:       return $urandom_range(7, 40);
			default: return $urandom_range(58, 250);
		endcase
	endfunction

	function automatic int unsigned pick_near();
		case ($urandom_range(3))
			0:       return 0;
			1:       return 1130;
			default: return $urandom_range(0, 4);
		endcase
	endfunction

	task automatic random_echo();
		int unsigned cap;
		int unsigned rise_wait;
		int unsigned pulse;
		cap       = (tracker.timeout_us < 200) ? tracker.timeout_us : 200;
		rise_wait = ($urandom_range(3) == 0) ? around(tracker.timeout_us) : $urandom_range(3);
		pulse     = ($urandom_range(3) == 0) ? around(tracker.timeout_us)
			: $urandom_range(1, cap);
		settle_idle();
		run_echo(rise_wait, pulse, 1'($urandom_range(1)));
		repeat ($urandom_range(3)) send_tick(1'b0, 1'($urandom_range(1)));
	endtask

	initial begin
		int unsigned target;
		tracker       = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		tick_if.valid = 1'b0;
		tick_if.data  = '0;
		res_if.ready  = 1'b0;
		src_idle_pct  = 0;
		snk_idle_pct  = 0;
		ticks_sent    = 0;
		stall_cycles  = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: 58 us is one centimetre, inside the near threshold
		run_echo(0, CM_DIV, 1'b1);

		// Shortest budget: one-tick pulses pass, a second low or high tick fails
		write_reg(uer_pkg::REG_TIMEOUT, 1);
		write_reg(uer_pkg::REG_NEAR, 0);
		run_echo(0, 1, 1'b1);
		run_echo(1, 1, 1'b1);
		run_echo(2, 1, 1'b0);
		settle_idle();
		run_echo(0, 2, 1'b0);
		settle_idle();

		// One centimetre with a zero threshold: never too close
		write_reg(uer_pkg::REG_TIMEOUT, 100);
		run_echo(3, CM_DIV, 1'b1);

		// Widest budget and widest threshold: one inch is well inside both
		write_reg(uer_pkg::REG_TIMEOUT, 65535);
		write_reg(uer_pkg::REG_NEAR, 1130);
		run_echo(0, INCH_DIV, 1'b1);
		settle_idle();

		// Random part: sender idles lightly and receiver heavily, then the
		// other way round, then neither; two register settings per regime
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle_pct = 16;
					snk_idle_pct = 58;
				end
				1: begin
					src_idle_pct = 58;
					snk_idle_pct = 16;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < 2; s++) begin
				settle_idle();
				write_reg(uer_pkg::REG_TIMEOUT, pick_timeout());
				write_reg(uer_pkg::REG_NEAR, pick_near());
				target = ticks_sent + RANDOM_TICKS / RANDOM_PHASES;
				while (ticks_sent < target) begin
					if ($urandom_range(7) == 0)
						send_noise();
					else
						random_echo();
				end
			end
		end

		// Drain: release the channel and wait for every reading still owed
		settle_idle();
		tick_if.valid <= 1'b0;
		while (!tracker.drained())
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("ultrasonic_echo_ranger verification clean");
		else
			$display("ultrasonic_echo_ranger verification failed");
		$finish;
	end

endmodule
